FILE: hdl/ctse_pkg.sv
// Package for the time-setting editor: payload structs, mode and field codes,
// and the per-field bounds. No dependencies.
package ctse_pkg;

	localparam int FIELD_COUNT = 7;
	localparam int VALUE_W     = 7;

	// Button / command codes
	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_UP     = 2'd1;
	localparam logic [1:0] MODE_SELECT = 2'd2;
	localparam logic [1:0] MODE_DOWN   = 2'd3;

	// Field codes, in select order
	localparam logic [2:0] FIELD_HOUR    = 3'd0;
	localparam logic [2:0] FIELD_MINUTE  = 3'd1;
	localparam logic [2:0] FIELD_SECOND  = 3'd2;
	localparam logic [2:0] FIELD_WEEKDAY = 3'd3;
	localparam logic [2:0] FIELD_DAY     = 3'd4;
	localparam logic [2:0] FIELD_MONTH   = 3'd5;
	localparam logic [2:0] FIELD_YEAR    = 3'd6;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic [2:0] weekday;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} ctse_time_t;

	localparam ctse_time_t TIME_RESET = '{hour: 5'd0, minute: 6'd0, second: 6'd0,
		weekday: 3'd0, day: 5'd1, month: 4'd1, year: 7'd0};

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] load_hour;
		logic [5:0] load_minute;
		logic [5:0] load_second;
		logic [2:0] load_weekday;
		logic [4:0] load_day;
		logic [3:0] load_month;
		logic [6:0] load_year;
	} ctse_in_t;

	typedef struct packed {
		logic       editing;
		logic [2:0] field_index;
		logic [6:0] shown_value;
		logic       commit;
		logic [4:0] out_hour;
		logic [5:0] out_minute;
		logic [5:0] out_second;
		logic [2:0] out_weekday;
		logic [4:0] out_day;
		logic [3:0] out_month;
		logic [6:0] out_year;
	} ctse_out_t;

	function automatic logic [VALUE_W-1:0] field_lo(input logic [2:0] field);
		logic [VALUE_W-1:0] lo;
		unique case (field)
			FIELD_DAY, FIELD_MONTH: lo = 7'd1;
			default:                lo = 7'd0;
		endcase
		return lo;
	endfunction

	function automatic logic [VALUE_W-1:0] field_hi(input logic [2:0] field);
		logic [VALUE_W-1:0] hi;
		unique case (field)
			FIELD_HOUR:    hi = 7'd23;
			FIELD_MINUTE:  hi = 7'd59;
			FIELD_SECOND:  hi = 7'd59;
			FIELD_WEEKDAY: hi = 7'd6;
			FIELD_DAY:     hi = 7'd31;
			FIELD_MONTH:   hi = 7'd12;
			default:       hi = 7'd99;
		endcase
		return hi;
	endfunction

	// Value of one field, zero-extended; codes past year read year
	function automatic logic [VALUE_W-1:0] field_pick(input ctse_time_t t,
		input logic [2:0] field);
		logic [VALUE_W-1:0] v;
		unique case (field)
			FIELD_HOUR:    v = {2'd0, t.hour};
			FIELD_MINUTE:  v = {1'd0, t.minute};
			FIELD_SECOND:  v = {1'd0, t.second};
			FIELD_WEEKDAY: v = {4'd0, t.weekday};
			FIELD_DAY:     v = {2'd0, t.day};
			FIELD_MONTH:   v = {3'd0, t.month};
			default:       v = t.year;
		endcase
		return v;
	endfunction

endpackage

FILE: hdl/ctse_in_if.sv
// Input channel of the time-setting editor: valid/ready plus button payload.
// Depends on ctse_pkg.
interface ctse_in_if;
	logic              valid;
	logic              ready;
	ctse_pkg::ctse_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/ctse_out_if.sv
// Result channel of the time-setting editor: valid/ready plus result payload.
// Depends on ctse_pkg.
interface ctse_out_if;
	logic               valid;
	logic               ready;
	ctse_pkg::ctse_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/clock_time_set_editor_core.sv
// Top level of the button-driven time-setting editor.
// Depends on ctse_pkg, ctse_in_if, ctse_out_if, ctse_field_step, ctse_out_buf.

// Takes one button event per cycle: load copies the given time and starts
// editing at the hour field, up and down wrap the field being edited, select
// moves to the next field, and select on year ends editing with a commit that
// carries the whole edited time. Every accepted event yields exactly one
// result, registered and shown after any results already buffered. The editor
// state updates in the same cycle as the transfer, so the sustained rate is
// one event per cycle; a two-entry output buffer holds results while the
// sink stalls, and in_ch.ready drops only when both entries are full.
module clock_time_set_editor_core (
	input  logic      clk,
	input  logic      arst_n,
	ctse_in_if.sink   in_ch,
	ctse_out_if.source out_ch
);
	import ctse_pkg::*;

	logic       active_q;
	logic [2:0] edit_step_q;
	ctse_time_t work_q;

	logic       accept;
	logic       buf_full;
	logic [6:0] cur_value;
	logic [6:0] step_value;
	logic [2:0] next_field;

	logic       active_d;
	logic [2:0] edit_step_d;
	ctse_time_t work_d;
	ctse_out_t  result;
	ctse_in_t   item;

	assign item        = in_ch.data;
	assign in_ch.ready = !buf_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign cur_value   = field_pick(work_q, edit_step_q);
	assign next_field  = edit_step_q + 3'd1;

	ctse_field_step u_step (
		.field (edit_step_q),
		.value (cur_value),
		.down  (item.mode == MODE_DOWN),
		.next  (step_value)
	);

	always_comb begin
		active_d    = active_q;
		edit_step_d = edit_step_q;
		work_d      = work_q;
		result      = '0;
		unique case (item.mode)
			MODE_LOAD: begin
				active_d       = 1'b1;
				edit_step_d    = FIELD_HOUR;
				work_d.hour    = item.load_hour;
				work_d.minute  = item.load_minute;
				work_d.second  = item.load_second;
				work_d.weekday = item.load_weekday;
				work_d.day     = item.load_day;
				work_d.month   = item.load_month;
				work_d.year    = item.load_year;
				result.editing     = 1'b1;
				result.field_index = FIELD_HOUR;
				result.shown_value = {2'd0, item.load_hour};
			end
			MODE_UP, MODE_DOWN: begin
				if (active_q) begin
					unique case (edit_step_q)
						FIELD_HOUR:    work_d.hour    = step_value[4:0];
						FIELD_MINUTE:  work_d.minute  = step_value[5:0];
						FIELD_SECOND:  work_d.second  = step_value[5:0];
						FIELD_WEEKDAY: work_d.weekday = step_value[2:0];
						FIELD_DAY:     work_d.day     = step_value[4:0];
						FIELD_MONTH:   work_d.month   = step_value[3:0];
						default:       work_d.year    = step_value;
					endcase
					result.editing     = 1'b1;
					result.field_index = edit_step_q;
					result.shown_value = step_value;
				end
			end
			default: begin
				// select
				if (active_q) begin
					if (edit_step_q >= FIELD_YEAR) begin
						active_d           = 1'b0;
						edit_step_d        = FIELD_HOUR;
						result.commit      = 1'b1;
						result.field_index = FIELD_YEAR;
						result.shown_value = work_q.year;
						result.out_hour    = work_q.hour;
						result.out_minute  = work_q.minute;
						result.out_second  = work_q.second;
						result.out_weekday = work_q.weekday;
						result.out_day     = work_q.day;
						result.out_month   = work_q.month;
						result.out_year    = work_q.year;
					end else begin
						edit_step_d        = next_field;
						result.editing     = 1'b1;
						result.field_index = next_field;
						result.shown_value = field_pick(work_q, next_field);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			edit_step_q <= FIELD_HOUR;
			work_q      <= TIME_RESET;
		end else if (accept) begin
			active_q    <= active_d;
			edit_step_q <= edit_step_d;
			work_q      <= work_d;
		end
	end

	ctse_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		edit_step_q <= FIELD_YEAR)
		else $error("edit step past year field");

	a_commit_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && active_q && item.mode == MODE_SELECT && edit_step_q == FIELD_YEAR)
		|=> (!active_q && edit_step_q == FIELD_HOUR))
		else $error("editor did not go idle after commit");

	a_load_starts_edit: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == MODE_LOAD) |=> (active_q && edit_step_q == FIELD_HOUR))
		else $error("load did not start editing at hour");

	a_commit_not_editing: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.commit) |-> !out_ch.data.editing)
		else $error("commit result still marked as editing");
`endif
endmodule

FILE: hdl/ctse_field_step.sv
// Up/down wrap stepper for one time field, bounds chosen by field code.
// Depends on ctse_pkg.
module ctse_field_step (
	input  logic [2:0] field,
	input  logic [6:0] value,
	input  logic       down,
	output logic [6:0] next
);
	import ctse_pkg::*;

	logic [VALUE_W-1:0] lo;
	logic [VALUE_W-1:0] hi;

	assign lo = field_lo(field);
	assign hi = field_hi(field);

	always_comb begin
		if (down) begin
			next = (value <= lo) ? hi : value - 7'd1;
		end else begin
			next = (value >= hi) ? lo : value + 7'd1;
		end
	end
endmodule

FILE: hdl/ctse_out_buf.sv
// Two-entry result buffer (output register plus skid register) that keeps the
// input side moving while a result waits. Depends on ctse_pkg and ctse_out_if.
module ctse_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ctse_pkg::ctse_out_t push_data,
	output logic               full,
	ctse_out_if.source         out_ch
);
	import ctse_pkg::*;

	logic      out_valid_q;
	logic      skid_valid_q;
	ctse_out_t out_data_q;
	ctse_out_t skid_data_q;
	logic      load_out;

	assign full         = skid_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_data_q;
	// output slot takes new data when empty or being drained this cycle
	assign load_out     = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (skid_valid_q) begin
				out_data_q  <= skid_data_q;
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end
endmodule
